// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define RGCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define RGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rgcd_pkg.sv
// shared types for the rational gcd unit
`timescale 1ns / 1ps

package rgcd_pkg;

  typedef enum logic [1:0] {
    OP_GCD    = 2'd0,
    OP_LCM    = 2'd1,
    OP_REDUCE = 2'd2,
    OP_EQUAL  = 2'd3
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_end;
    logic div_step;
    logic mul_first;
    logic mul_second;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic gcd_done;
    logic div_last;
    logic zero_pair;
    op_t  op;
  } dp_sts_t;

endpackage

// File: design/rgcd_ctrl.sv
// sequencing state machine of the rational gcd unit
`timescale 1ns / 1ps

module rgcd_ctrl
  import rgcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_stall,
  output logic    out_valid,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GCD  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MULA = 6'b001000,
    S_MULB = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (op_t'(sts.op) == OP_EQUAL) ? S_MULA : S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.gcd_end = 1'b1;
          if (sts.op == OP_GCD || sts.zero_pair) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = (sts.op == OP_LCM) ? S_MULA : S_FIN;
        end
      end
      S_MULA: begin
        cmd.mul_first = 1'b1;
        state_nxt     = (sts.op == OP_EQUAL) ? S_MULB : S_FIN;
      end
      S_MULB: begin
        cmd.mul_second = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/rgcd_dp.sv
// operand registers, binary gcd, dual divider, shared multiplier and result register
`timescale 1ns / 1ps

module rgcd_dp
  import rgcd_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_first_value,
  input  logic [15:0] in_second_value,
  input  logic [15:0] in_third_value,
  input  logic [15:0] in_fourth_value,
  output logic [31:0] out_main_result,
  output logic [15:0] out_second_result,
  output logic        out_is_equal,
  output logic        out_divide_error
);

  localparam int W  = VALUE_WIDTH;
  localparam int KW = $clog2(W + 1);
  localparam int CW = $clog2(W);
  localparam int PW = 2 * W;

  // operands in their low W bits
  logic [31:0]  a32, b32, c32, d32;
  logic [W-1:0] a_in, b_in, c_in, d_in;

  assign a32  = {16'd0, in_first_value};
  assign b32  = {16'd0, in_second_value};
  assign c32  = {16'd0, in_third_value};
  assign d32  = {16'd0, in_fourth_value};
  assign a_in = a32[W-1:0];
  assign b_in = b32[W-1:0];
  assign c_in = c32[W-1:0];
  assign d_in = d32[W-1:0];

  op_t          op_r;
  logic         zero_pair_r;
  logic [W-1:0] a_r, b_r, c_r, d_r;
  logic [W-1:0] u_r, v_r, u_nxt, v_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W-1:0] g_r, g_nxt, g_src;
  logic [W-1:0] qa_r, qb_r, ra_r, rb_r;
  logic [W-1:0] qa_nxt, qb_nxt, ra_nxt, rb_nxt;
  logic [CW-1:0] dcnt_r;
  logic [PW-1:0] prod_r, cross_r, prod_c;
  logic [W-1:0] mul_x, mul_y;

  // binary gcd step: halve even values, subtract and halve when both odd
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    priority if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + KW'(1);
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  assign g_src = (u_r == '0) ? v_r : u_r;
  assign g_nxt = g_src << k_r;

  // restoring division of both operands by the gcd
  logic [W:0] ta, tb, da, db;
  assign ta = {ra_r, qa_r[W-1]};
  assign tb = {rb_r, qb_r[W-1]};
  assign da = ta - {1'b0, g_r};
  assign db = tb - {1'b0, g_r};

  always_comb begin
    if (ta >= {1'b0, g_r}) begin
      ra_nxt = da[W-1:0];
      qa_nxt = {qa_r[W-2:0], 1'b1};
    end else begin
      ra_nxt = ta[W-1:0];
      qa_nxt = {qa_r[W-2:0], 1'b0};
    end
    if (tb >= {1'b0, g_r}) begin
      rb_nxt = db[W-1:0];
      qb_nxt = {qb_r[W-2:0], 1'b1};
    end else begin
      rb_nxt = tb[W-1:0];
      qb_nxt = {qb_r[W-2:0], 1'b0};
    end
  end

  // one shared multiplier
  always_comb begin
    if (cmd.mul_second) begin
      mul_x = c_r;
      mul_y = b_r;
    end else if (op_r == OP_EQUAL) begin
      mul_x = a_r;
      mul_y = d_r;
    end else begin
      mul_x = qa_r;
      mul_y = b_r;
    end
  end

  assign prod_c = PW'(mul_x) * PW'(mul_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op_t'(in_operation);
      zero_pair_r <= (a_in == '0) && (b_in == '0);
      a_r         <= a_in;
      b_r         <= b_in;
      c_r         <= c_in;
      d_r         <= d_in;
      u_r         <= a_in;
      v_r         <= b_in;
      k_r         <= '0;
    end else if (cmd.gcd_step) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end
    if (cmd.gcd_end) begin
      g_r    <= g_nxt;
      qa_r   <= a_r;
      qb_r   <= b_r;
      ra_r   <= '0;
      rb_r   <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      qa_r   <= qa_nxt;
      qb_r   <= qb_nxt;
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
      dcnt_r <= dcnt_r + CW'(1);
    end
    if (cmd.mul_first || cmd.mul_second) begin
      prod_r <= prod_c;
    end
    if (cmd.mul_second) begin
      cross_r <= prod_r;
    end
  end

  assign sts.gcd_done  = (u_r == '0) || (v_r == '0);
  assign sts.div_last  = (dcnt_r == CW'(W - 1));
  assign sts.zero_pair = zero_pair_r;
  assign sts.op        = cmd.load ? op_t'(in_operation) : op_r;

  // result formation
  logic [63:0] prod64;
  logic [31:0] main_c;
  logic [15:0] second_c;
  logic        eq_c, err_c;

  assign prod64 = 64'(prod_r);

  always_comb begin
    main_c   = '0;
    second_c = '0;
    eq_c     = 1'b0;
    err_c    = 1'b0;
    unique case (op_r)
      OP_GCD: main_c = 32'(g_r);
      OP_LCM: begin
        err_c = zero_pair_r;
        if (!zero_pair_r) begin
          main_c = (prod64[63:32] != '0) ? '1 : prod64[31:0];
        end
      end
      OP_REDUCE: begin
        err_c = zero_pair_r;
        if (!zero_pair_r) begin
          main_c   = 32'(qa_r);
          second_c = 16'(qb_r);
        end
      end
      OP_EQUAL: eq_c = (cross_r == prod_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_main_result   <= main_c;
      out_second_result <= second_c;
      out_is_equal      <= eq_c;
      out_divide_error  <= err_c;
    end
  end

endmodule

// File: design/rational_gcd_unit.sv
// top level of the rational gcd unit: controller plus datapath
`timescale 1ns / 1ps

// Rational gcd unit. Each input item asks for one of four things on unsigned
// operands taken in their low VALUE_WIDTH bits: the gcd of first and second
// value, their lcm (saturated to 32 bits), the fraction first/second reduced
// by its gcd, or the equality of first/second and third/fourth by cross
// products. Every item gives exactly one result item. lcm or reduce of zero
// and zero sets divide_error and returns zero results. One item is worked on
// at a time; the next item is taken as soon as the previous result sits in
// the output register, even if that result is still stalled.
// Sequence, with W = VALUE_WIDTH: an accept step, then the binary gcd loop
// (one halve or subtract-and-halve per cycle, then a finishing step that
// registers the gcd), then two restoring dividers running side by side for
// lcm and reduce, then the shared W x W multiplier for lcm, and last the
// load of the output register. Equality skips the gcd and uses the
// multiplier twice.

module rational_gcd_unit
  import rgcd_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_first_value,
  input  logic [15:0] in_second_value,
  input  logic [15:0] in_third_value,
  input  logic [15:0] in_fourth_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_main_result,
  output logic [15:0] out_second_result,
  output logic        out_is_equal,
  output logic        out_divide_error
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accept, gcd loop, divide, multiply, hand off to output register
  rgcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: operand store, gcd, dividers, multiplier, result register
  rgcd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_first_value    (in_first_value),
    .in_second_value   (in_second_value),
    .in_third_value    (in_third_value),
    .in_fourth_value   (in_fourth_value),
    .out_main_result   (out_main_result),
    .out_second_result (out_second_result),
    .out_is_equal      (out_is_equal),
    .out_divide_error  (out_divide_error)
  );

endmodule

// File: design/rgcd_checker.sv
// port-level checks for the rational gcd unit and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_operation,
  input logic [15:0] in_first_value,
  input logic [15:0] in_second_value,
  input logic [15:0] in_third_value,
  input logic [15:0] in_fourth_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_main_result,
  input logic [15:0] out_second_result,
  input logic        out_is_equal,
  input logic        out_divide_error
);

  // a stalled result item stays put
  `RGCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_main_result) && $stable(out_second_result)
    && $stable(out_is_equal) && $stable(out_divide_error), "stalled result changed")

  // one item at a time: the unit is busy right after an accept
  `RGCD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall,
    in_stall, "second item taken while busy")

  // a divide error gives zero results and no equality
  `RGCD_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_divide_error,
    out_main_result == 32'd0 && out_second_result == 16'd0 && !out_is_equal,
    "divide error with nonzero result")

  // equality reports carry no numeric result
  `RGCD_ASSERT_NOW(a_eq_clean, clk, rst_n, out_valid && out_is_equal,
    out_main_result == 32'd0 && out_second_result == 16'd0,
    "equality result with numeric fields set")

endmodule

bind rational_gcd_unit rgcd_checker u_rgcd_checker (.*);
